FILE: design/fvn_pkg.sv
// shared constants for the fractal value noise pipeline
package fvn_pkg;

  // lattice hash multipliers
  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] HASH_KZ = 32'd3266489917;
  localparam logic [31:0] HASH_KM = 32'd1274126177;

  // one in q1.16 and the smoothstep constant 3.0
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  // configuration register indexes
  localparam logic [1:0] REG_SEED    = 2'd0;
  localparam logic [1:0] REG_OCTAVES = 2'd1;
  localparam logic [1:0] REG_PERSIST = 2'd2;

endpackage

FILE: design/fractal_value_noise_3d.sv
// top level of the fractal value noise pipeline
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  coord_x, coord_y, coord_z (signed q16.16)
// out      output     out_valid / out_stall noise_value (q0.16)
// cfg      input      cfg_we               cfg_index, cfg_data
//
// one item enters per cycle unless the output stalls; the registers from transfer to result are
// the input register, 7 lane stages, weighting, 2 summing stages and 16 divider stages.
// all octaves run as parallel lanes; the normalising divide sets the depth.
// a stalled output freezes the whole pipeline; no item is lost or repeated.
// reset clears valid bits and sets config to its defaults; octave weights settle along
// their register chain after a persistence write.
module fractal_value_noise_3d import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] noise_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TW = 17 + $clog2(MAX_OCTAVES);
  localparam int NW = TW + 16;
  localparam int NG = (MAX_OCTAVES + 3) / 4;

  logic        adv;
  logic [31:0] noise_seed;
  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic [4:0]  n_eff;
  logic [16:0] amp [MAX_OCTAVES];
  logic [31:0] cx0, cy0, cz0;
  logic [15:0] lane_v [MAX_OCTAVES];
  logic [32:0] prod [MAX_OCTAVES];
  logic [16:0] ampm [MAX_OCTAVES];
  logic [NW-1:0] gp [NG];
  logic [TW-1:0] ga [NG];
  logic [NW-1:0] numer;
  logic [TW-1:0] total;
  logic [10:0] vld;

  // pipeline moves unless a result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed   <= 32'd12346;
      octave_count <= 4'd4;
      persistence  <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:    noise_seed   <= cfg_data;
        REG_OCTAVES: octave_count <= cfg_data[3:0];
        REG_PERSIST: persistence  <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  // clamp octave count to 1..MAX_OCTAVES
  always_comb begin
    if (octave_count == 4'd0) begin
      n_eff = 5'd1;
    end else if ({1'b0, octave_count} > 5'(MAX_OCTAVES)) begin
      n_eff = 5'(MAX_OCTAVES);
    end else begin
      n_eff = {1'b0, octave_count};
    end
  end

  // octave weights, one multiply per register along the chain
  assign amp[0] = ONE_Q16;
  for (genvar i = 1; i < MAX_OCTAVES; i++) begin : g_amp
    logic [32:0] ap;
    assign ap = amp[i-1] * persistence;
    always_ff @(posedge clk) begin
      if (rst) begin
        amp[i] <= 17'(ONE_Q16 >> i);
      end else begin
        amp[i] <= ap[32:16];
      end
    end
  end

  // valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[9:0], in_valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv) begin
      cx0 <= coord_x;
      cy0 <= coord_y;
      cz0 <= coord_z;
    end
  end

  // octave lanes
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    fvn_lane #(.SHIFT(i)) u_lane (
      .clk  (clk),
      .adv  (adv),
      .cx   (cx0),
      .cy   (cy0),
      .cz   (cz0),
      .seed (noise_seed),
      .v    (lane_v[i])
    );
  end

  // weight each octave, dropping unused ones
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        if (5'(i) < n_eff) begin
          prod[i] <= lane_v[i] * amp[i];
          ampm[i] <= amp[i];
        end else begin
          prod[i] <= '0;
          ampm[i] <= '0;
        end
      end
    end
  end

  // partial sums over groups of four octaves
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < NG; g++) begin
        logic [NW-1:0] sp;
        logic [TW-1:0] sa;
        sp = '0;
        sa = '0;
        for (int j = 0; j < 4; j++) begin
          if (4 * g + j < MAX_OCTAVES) begin
            sp = sp + NW'(prod[4*g+j]);
            sa = sa + TW'(ampm[4*g+j]);
          end
        end
        gp[g] <= sp;
        ga[g] <= sa;
      end
    end
  end

  // final sums and rounding offset
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [NW-1:0] sp;
      logic [TW-1:0] sa;
      sp = '0;
      sa = '0;
      for (int g = 0; g < NG; g++) begin
        sp = sp + gp[g];
        sa = sa + ga[g];
      end
      numer <= sp + NW'(sa >> 1);
      total <= sa;
    end
  end

  // normalise by the weight sum
  fvn_div #(.DW(TW), .NW(NW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (vld[10]),
    .num     (numer),
    .den     (total),
    .out_vld (out_valid),
    .quo     (noise_value)
  );

endmodule

FILE: design/fvn_lane.sv
// one octave of value noise: lattice, hash, smoothstep and trilinear blend
module fvn_lane import fvn_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] cx,
  input  logic [31:0] cy,
  input  logic [31:0] cz,
  input  logic [31:0] seed,
  output logic [15:0] v
);

  // signed lerp of two 16-bit corner values, weight 0..65536
  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [16:0] w);
    logic signed [16:0] d;
    logic signed [34:0] p;
    logic signed [34:0] sh;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    p  = d * $signed({1'b0, w});
    sh = (p + 35'sd32768) >>> 16;
    return a + sh[15:0];
  endfunction

  logic [31:0] coord [3];
  logic [31:0] kmul  [3];

  // stage 1 lattice
  logic [31:0] base0 [3];
  logic [31:0] base1 [3];
  logic [15:0] frac1 [3];
  logic [31:0] seed1;
  // stage 2 axis products
  logic [31:0] mk0 [3];
  logic [31:0] mk1 [3];
  logic [31:0] fsq [3];
  logic [15:0] frac2 [3];
  logic [31:0] seed2;
  // stage 3 hash mix and weights
  logic [31:0] mix [8];
  logic [16:0] w3 [3];
  // stage 4 final hash multiply
  logic [31:0] h4 [8];
  logic [16:0] w4 [3];
  // stages 5 and 6 blends
  logic [15:0] xb [4];
  logic [16:0] w5y;
  logic [16:0] w5z;
  logic [15:0] yb [2];
  logic [16:0] w6z;

  assign coord[0] = cx;
  assign coord[1] = cy;
  assign coord[2] = cz;
  assign kmul[0]  = HASH_KX;
  assign kmul[1]  = HASH_KY;
  assign kmul[2]  = HASH_KZ;

  // scale by the octave and split into lattice integer and fraction
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [47:0] sc;
        sc = {{16{coord[k][31]}}, coord[k]} << SHIFT;
        base0[k] <= sc[47:16];
        base1[k] <= sc[47:16] + 32'd1;
        frac1[k] <= sc[15:0];
      end
      seed1 <= seed + 32'(SHIFT);
    end
  end

  // per-axis hash products and fraction squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mk0[k]   <= base0[k] * kmul[k];
        mk1[k]   <= base1[k] * kmul[k];
        fsq[k]   <= {16'd0, frac1[k]} * {16'd0, frac1[k]};
        frac2[k] <= frac1[k];
      end
      seed2 <= seed1;
    end
  end

  // corner hash mixing and smoothstep weights
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        logic [31:0] h;
        h = seed2 ^ (c[0] ? mk1[0] : mk0[0]) ^ (c[1] ? mk1[1] : mk0[1])
                  ^ (c[2] ? mk1[2] : mk0[2]);
        mix[c] <= h ^ (h >> 13);
      end
      for (int k = 0; k < 3; k++) begin
        logic [49:0] p;
        p = {18'd0, fsq[k]} * {32'd0, THREE_Q16 - {1'b0, frac2[k], 1'b0}};
        p = p + 50'h0_8000_0000;
        w3[k] <= p[48:32];
      end
    end
  end

  // final hash multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        h4[c] <= mix[c] * HASH_KM;
      end
      w4 <= w3;
    end
  end

  // blend along x
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        xb[j] <= blend(h4[2*j][15:0] ^ h4[2*j][31:16],
                       h4[2*j+1][15:0] ^ h4[2*j+1][31:16], w4[0]);
      end
      w5y <= w4[1];
      w5z <= w4[2];
    end
  end

  // blend along y
  always_ff @(posedge clk) begin
    if (adv) begin
      yb[0] <= blend(xb[0], xb[1], w5y);
      yb[1] <= blend(xb[2], xb[3], w5y);
      w6z   <= w5z;
    end
  end

  // blend along z
  always_ff @(posedge clk) begin
    if (adv) begin
      v <= blend(yb[0], yb[1], w6z);
    end
  end

endmodule

FILE: design/fvn_div.sv
// pipelined restoring divider, one quotient bit per stage, 16-bit quotient
module fvn_div import fvn_pkg::*; #(
  parameter int DW = 20,
  parameter int NW = 36
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_vld,
  output logic [15:0]   quo
);

  logic [NW-1:0] rem [17];
  logic [DW-1:0] dd  [17];
  logic [15:0]   q   [17];
  logic          vld [17];

  assign rem[0] = num;
  assign dd[0]  = den;
  assign q[0]   = 16'd0;
  assign vld[0] = in_vld;

  for (genvar s = 0; s < 16; s++) begin : g_stage
    localparam int B = 15 - s;
    logic [NW-1:0] sub;
    assign sub = NW'(dd[s]) << B;

    // trial subtract of the shifted divisor
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem[s] >= sub) begin
          rem[s+1] <= rem[s] - sub;
          q[s+1]   <= q[s] | (16'd1 << B);
        end else begin
          rem[s+1] <= rem[s];
          q[s+1]   <= q[s];
        end
        dd[s+1] <= dd[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end
  end

  assign out_vld = vld[16];
  assign quo     = q[16];

endmodule

FILE: bench/tb_fractal_value_noise_3d.sv
// self-checking testbench for the fractal value noise pipeline
`timescale 1ns / 100ps

module tb_fractal_value_noise_3d;
  import fvn_pkg::*;

  localparam int MAX_OCT    = 8;
  localparam int LATENCY    = 27;
  localparam int CYCLE_STOP = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic [31:0] coord_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] noise_value;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the configuration
  logic [31:0] seed_q;
  logic [3:0]  octaves_q;
  logic [15:0] persist_q;

  logic [15:0] noise_expected[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          random_stall = 1'b1;

  fractal_value_noise_3d u_top (.*);

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_STOP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // lattice hash
  function automatic logic [31:0] mix_hash(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [31:0] s);
    logic [31:0] h;
    h = s ^ (x * HASH_KX) ^ (y * HASH_KY) ^ (z * HASH_KZ);
    h = (h ^ (h >> 13)) * HASH_KM;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] ease_weight(logic [31:0] f);
    logic [63:0] p;
    p = 64'(f) * 64'(f) * 64'(32'd196608 - 2 * f);
    return 32'((p + 64'h8000_0000) >> 32);
  endfunction

  function automatic logic [31:0] mix_lerp(logic [31:0] a, logic [31:0] b, logic [31:0] w);
    logic [63:0] s;
    s = 64'(a) * 64'(32'd65536 - w) + 64'(b) * 64'(w) + 64'd32768;
    return 32'(s >> 16);
  endfunction

  // one octave of trilinear value noise
  function automatic logic [31:0] octave_noise(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz, int shift, logic [31:0] s);
    logic [63:0] sc;
    logic [31:0] base[3];
    logic [31:0] w[3];
    logic [31:0] v[8];
    logic [31:0] c[3];
    logic [31:0] x00, x10, x01, x11, y0, y1;
    c[0] = cx; c[1] = cy; c[2] = cz;
    for (int k = 0; k < 3; k++) begin
      sc = {{32{c[k][31]}}, c[k]} << shift;
      base[k] = sc[47:16];
      w[k] = ease_weight({16'd0, sc[15:0]});
    end
    for (int k = 0; k < 8; k++)
      v[k] = mix_hash(base[0] + k[0], base[1] + k[1], base[2] + k[2], s) & 32'hFFFF;
    x00 = mix_lerp(v[0], v[1], w[0]);
    x10 = mix_lerp(v[2], v[3], w[0]);
    x01 = mix_lerp(v[4], v[5], w[0]);
    x11 = mix_lerp(v[6], v[7], w[0]);
    y0 = mix_lerp(x00, x10, w[1]);
    y1 = mix_lerp(x01, x11, w[1]);
    return mix_lerp(y0, y1, w[2]);
  endfunction

  function automatic logic [15:0] fractal_noise(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] cz);
    int          n;
    logic [31:0] amp;
    logic [63:0] acc, total;
    n = octaves_q;
    amp = 32'd65536;
    acc = 0;
    total = 0;
    if (n < 1) n = 1;
    if (n > MAX_OCT) n = MAX_OCT;
    for (int i = 0; i < n; i++) begin
      acc += 64'(octave_noise(cx, cy, cz, i, seed_q + i)) * amp;
      total += amp;
      amp = 32'((64'(amp) * persist_q) >> 16);
    end
    return 16'((acc + total / 2) / total);
  endfunction

  // result checker
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (noise_expected.size() == 0) begin
        $error("unexpected noise_value %0d", noise_value);
        fail_count++;
      end else begin
        want = noise_expected.pop_front();
        if (noise_value !== want) begin
          $error("noise_value expected %0d actual %0d", want, noise_value);
          fail_count++;
        end
      end
    end
  end

  // receiver stall: random gaps or a long hold-off
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (random_stall) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // send one point, predicting its result
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps = 1);
    int gap;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    noise_expected.push_back(fractal_noise(x, y, z));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SEED:    seed_q = data;
      REG_OCTAVES: octaves_q = data[3:0];
      REG_PERSIST: persist_q = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (MAX_OCT + 2) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] s, logic [3:0] n, logic [15:0] p);
    drain();
    write_reg(REG_SEED, s);
    write_reg(REG_OCTAVES, {28'd0, n});
    write_reg(REG_PERSIST, {16'd0, p});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
      2: return {{12{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 20'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7FFF_0000 + 16'($urandom())
                                          : 32'h8000_0000 + 16'($urandom());
    endcase
  endfunction

  // extremes of the coordinates, special register values
  task automatic test_directed();
    logic [31:0] edges[8] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h0000_8000, 32'h0001_0000, 32'h5555_AAAA, 32'hAAAA_5555};
    for (int i = 0; i < 8; i++) send_point(edges[i], edges[(i + 3) % 8], edges[7 - i]);
    configure(32'hFFFF_FFFF, 4'd0, 16'd0);      // zero octaves, zero persistence
    for (int i = 0; i < 4; i++) send_point(edges[i], edges[i + 4], edges[i]);
    configure(32'h0, 4'd15, 16'hFFFF);          // octave count above maximum
    for (int i = 0; i < 6; i++) send_point(edges[i], edges[7 - i], edges[(i + 5) % 8]);
    configure(32'hFFFF_FFFE, 4'd8, 16'd1);      // seed wrap across octaves
    for (int i = 0; i < 4; i++) send_point(edges[i + 1], edges[i], edges[i + 2]);
    drain();
    // out-of-range register index is ignored
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= $urandom();
    @(negedge clk);
    cfg_we <= 1'b0;
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0);
  endtask

  task automatic test_random(int count);
    for (int phase = 0; phase < 8; phase++) begin
      configure($urandom(), 4'($urandom_range(0, 15)), 16'($urandom()));
      for (int i = 0; i < count / 8; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // receiver holds off, sender keeps pushing until the block backs up
  task automatic test_backpressure();
    configure(32'd12346, 4'd8, 16'd40000);
    random_stall = 1'b0;
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_point(rand_coord(), rand_coord(), rand_coord(), 0);
    drain();
    random_stall = 1'b1;
    for (int i = 0; i < 40; i++) send_point(rand_coord(), rand_coord(), rand_coord(), 0);
  endtask

  initial begin
    seed_q = 32'd12346;
    octaves_q = 4'd4;
    persist_q = 16'd32768;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1520);
    test_backpressure();
    drain();
    if (fail_count == 0 && noise_expected.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/fvn_pkg.sv
design/fvn_lane.sv
design/fvn_div.sv
design/fractal_value_noise_3d.sv
bench/tb_fractal_value_noise_3d.sv
